// ===== src/ctl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_pkg: shared types and constants of the connection timeout list
// Command and status codes, register indexes, the sequencer states and the
// result request that travels from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package ctl_pkg;

  // Width of a stored expiry time in seconds.
  localparam int unsigned EXP_W = 34;
  // Width of the current time field.
  localparam int unsigned NOW_W = 32;
  // Width of the period count times slot length product.
  localparam int unsigned PROD_W = 24;

  // Configuration port.
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 16;
  localparam logic [CFG_AW-1:0] CFG_TIMESLOT = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_PERIODS  = 2'd1;
  localparam logic [15:0] TIMESLOT_RST = 16'd5;
  localparam logic [7:0]  PERIODS_RST  = 8'd3;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STS_DONE      = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_FULL      = 3'd2,
    STS_EXPIRED   = 3'd3,
    STS_NONE      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_FIND,
    ST_SHD,
    ST_INS,
    ST_TK_RD,
    ST_TK_CK,
    ST_TK_END,
    ST_RESP
  } state_e;

  // Result request from the sequencer to the output stage.
  typedef struct packed {
    logic    valid;
    status_e status;
    logic    last;
  } push_t;

endpackage

// ===== src/ctl_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_mem: entry store of the timeout list
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ctl_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 44,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ctl_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_out: result output register
// Holds one result until the receiver takes it, so the sequencer can go on
// while a finished result waits.
// ----------------------------------------------------------------------------
module ctl_out #(
  parameter int unsigned ID_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_pkg::push_t     push_i,
  input  logic [ID_BITS-1:0] push_id_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [ID_BITS-1:0] expired_id_o,
  output logic               last_o
);

  import ctl_pkg::*;

  logic               valid_q, valid_d;
  status_e            status_q;
  logic [ID_BITS-1:0] id_q;
  logic               last_q;

  // The register can take a new result when empty or being drained.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i.valid) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload loads only on a new result.
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      status_q <= push_i.status;
      id_q     <= push_id_i;
      last_q   <= push_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign status_o     = status_q;
  assign expired_id_o = id_q;
  assign last_o       = last_q;

endmodule

// ===== src/ctl_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_seq: command sequencer of the timeout list
// Walks the entry store, one entry per cycle in its streaming passes, to find,
// insert, remove and expire entries, and computes expiry times.
// ----------------------------------------------------------------------------
module ctl_seq #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ID_BITS     = 10,
  parameter int unsigned IDX_W       = 6,
  parameter int unsigned CNT_W       = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 idle_o,
  input  ctl_pkg::cmd_e                        cmd_i,
  input  logic [ID_BITS-1:0]                   conn_id_i,
  input  logic [ctl_pkg::NOW_W-1:0]            now_seconds_i,
  input  logic [15:0]                          timeslot_i,
  input  logic [7:0]                           periods_i,
  output logic                                 mem_re_o,
  output logic [IDX_W-1:0]                     mem_raddr_o,
  output logic                                 mem_we_o,
  output logic [IDX_W-1:0]                     mem_waddr_o,
  output logic [ctl_pkg::EXP_W+ID_BITS-1:0]    mem_wdata_o,
  input  logic [ctl_pkg::EXP_W+ID_BITS-1:0]    mem_rdata_i,
  input  logic                                 out_free_i,
  output ctl_pkg::push_t                       push_o,
  output logic [ID_BITS-1:0]                   push_id_o,
  output logic [CNT_W-1:0]                     count_o
);

  import ctl_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [NOW_W-1:0]   now_q, now_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [EXP_W-1:0]   key_q, key_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   rd_q, rd_d;
  logic [CNT_W-1:0]   rleft_q, rleft_d;
  logic               dv_q, dv_d;
  logic [IDX_W-1:0]   di_q, di_d;
  logic [CNT_W-1:0]   gap_q, gap_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic               pend_q, pend_d;
  logic [ID_BITS-1:0] pend_id_q, pend_id_d;
  status_e            status_q, status_d;

  logic [EXP_W-1:0]   rd_exp;
  logic [ID_BITS-1:0] rd_id;
  logic               cmp_le;
  logic               issue;

  // Fields of the entry just read, and the shared expiry comparator.
  assign rd_exp = mem_rdata_i[EXP_W+ID_BITS-1:ID_BITS];
  assign rd_id  = mem_rdata_i[ID_BITS-1:0];
  assign cmp_le = (rd_exp <= key_q);

  // The streaming passes read one entry per cycle while reads remain.
  assign issue = (state_q == ST_FIND || state_q == ST_SHD || state_q == ST_INS) &&
                 (rleft_q != '0);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    now_d       = now_q;
    prod_d      = prod_q;
    key_d       = key_q;
    count_d     = count_q;
    rd_d        = rd_q;
    rleft_d     = rleft_q;
    dv_d        = 1'b0;
    di_d        = di_q;
    gap_d       = gap_q;
    k_d         = k_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    status_d    = status_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    push_o      = '{valid: 1'b0, status: STS_DONE, last: 1'b1};
    push_id_o   = '0;

    // Stream reads: ascending for find and shift down, descending for insert.
    if (issue) begin
      mem_re_o = 1'b1;
      rleft_d  = rleft_q - CNT_W'(1);
      dv_d     = 1'b1;
      di_d     = rd_q;
      rd_d     = (state_q == ST_INS) ? rd_q - IDX_W'(1) : rd_q + IDX_W'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_i;
          id_d  = conn_id_i;
          now_d = now_seconds_i;
          case (cmd_i)
            CMD_ADD: begin
              if (count_q == DEPTH_C) begin
                status_d = STS_FULL;
                state_d  = ST_RESP;
              end else begin
                state_d = ST_MUL;
              end
            end
            CMD_REFRESH, CMD_REMOVE: begin
              rd_d    = '0;
              rleft_d = count_q;
              state_d = ST_FIND;
            end
            default: begin
              key_d   = EXP_W'(now_seconds_i);
              k_d     = '0;
              pend_d  = 1'b0;
              state_d = ST_TK_RD;
            end
          endcase
        end
      end

      // Timeout length in seconds, registered before the add.
      ST_MUL: begin
        prod_d  = PROD_W'(periods_i) * PROD_W'(timeslot_i);
        state_d = ST_ADD;
      end

      // New expiry; set up the insert pass from the tail.
      ST_ADD: begin
        key_d   = EXP_W'(now_q) + EXP_W'(prod_q);
        rd_d    = count_q[IDX_W-1:0] - IDX_W'(1);
        rleft_d = count_q;
        state_d = ST_INS;
      end

      // Search for the first entry that carries the id.
      ST_FIND: begin
        if (dv_q && rd_id == id_q) begin
          gap_d   = CNT_W'(1);
          rd_d    = di_q + IDX_W'(1);
          rleft_d = count_q - CNT_W'(di_q) - CNT_W'(1);
          dv_d    = 1'b0;
          state_d = ST_SHD;
        end else if (!dv_q && rleft_q == '0) begin
          status_d = STS_NOT_FOUND;
          state_d  = ST_RESP;
        end
      end

      // Close a gap: every entry behind it moves down by the gap size.
      ST_SHD: begin
        if (dv_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = di_q - gap_q[IDX_W-1:0];
        end else if (rleft_q == '0) begin
          count_d = count_q - gap_q;
          case (cmd_q)
            CMD_REFRESH: state_d = ST_MUL;
            CMD_REMOVE: begin
              status_d = STS_DONE;
              state_d  = ST_RESP;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      // Insertion from the tail: later entries move up until one is not later.
      ST_INS: begin
        if (dv_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = di_q + IDX_W'(1);
          if (cmp_le) begin
            mem_wdata_o = {key_q, id_q};
            count_d     = count_q + CNT_W'(1);
            status_d    = STS_DONE;
            dv_d        = 1'b0;
            state_d     = ST_RESP;
          end
        end else if (rleft_q == '0) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = '0;
          mem_wdata_o = {key_q, id_q};
          count_d     = count_q + CNT_W'(1);
          status_d    = STS_DONE;
          state_d     = ST_RESP;
        end
      end

      // Tick: read the next entry from the front.
      ST_TK_RD: begin
        if (k_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = k_q[IDX_W-1:0];
          state_d     = ST_TK_CK;
        end else begin
          state_d = ST_TK_END;
        end
      end

      // An expired entry is held back until it is known whether it is the last.
      ST_TK_CK: begin
        if (cmp_le) begin
          if (!pend_q || out_free_i) begin
            if (pend_q) begin
              push_o    = '{valid: 1'b1, status: STS_EXPIRED, last: 1'b0};
              push_id_o = pend_id_q;
            end
            pend_d    = 1'b1;
            pend_id_d = rd_id;
            k_d       = k_q + CNT_W'(1);
            state_d   = ST_TK_RD;
          end
        end else begin
          state_d = ST_TK_END;
        end
      end

      // Final tick result, then drop the expired entries from the front.
      ST_TK_END: begin
        if (out_free_i) begin
          if (pend_q) begin
            push_o    = '{valid: 1'b1, status: STS_EXPIRED, last: 1'b1};
            push_id_o = pend_id_q;
          end else begin
            push_o = '{valid: 1'b1, status: STS_NONE, last: 1'b1};
          end
          if (k_q != '0) begin
            gap_d   = k_q;
            rd_d    = k_q[IDX_W-1:0];
            rleft_d = count_q - k_q;
            state_d = ST_SHD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      // Single result of add, refresh and remove.
      ST_RESP: begin
        if (out_free_i) begin
          push_o  = '{valid: 1'b1, status: status_q, last: 1'b1};
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rleft_q <= '0;
      dv_q    <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rleft_q <= rleft_d;
      dv_q    <= dv_d;
      pend_q  <= pend_d;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    id_q      <= id_d;
    now_q     <= now_d;
    prod_q    <= prod_d;
    key_q     <= key_d;
    rd_q      <= rd_d;
    di_q      <= di_d;
    gap_q     <= gap_d;
    k_q       <= k_d;
    pend_id_q <= pend_id_d;
    status_q  <= status_d;
  end

  assign idle_o  = (state_q == ST_IDLE);
  assign count_o = count_q;

endmodule

// ===== src/connection_timeout_list_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_timeout_list_top: ordered list of connection timers
// Keeps connection ids sorted by expiry time and expires them on tick.
// ----------------------------------------------------------------------------
// One request is processed at a time; in_stall_o stays high until it is done.
// Requests walk the entry memory through its single registered read port, so
// the time grows with the entry count N. The find, shift and insert passes
// read one entry per cycle. A remove does a find pass and, when the id is
// found, a shift pass. An add does an insert pass, or none when the table is
// full. A refresh does a find pass and, when the id is found, a shift pass
// and an insert pass. A tick reads and checks entries from the front one by
// one up to the first that has not expired, then closes any gap at the front
// with a shift pass. A stalled receiver can lengthen a request. A waiting
// result sits in the output register and holds up the sequencer only when a
// further result is ready. Configuration writes are taken only between
// requests and go ahead of a waiting request. There is no clearing pass after
// reset.
// ----------------------------------------------------------------------------
module connection_timeout_list_top #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ID_BITS     = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic [ID_BITS-1:0]          conn_id_i,
  input  logic [ctl_pkg::NOW_W-1:0]   now_seconds_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [ID_BITS-1:0]          expired_id_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ctl_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [ctl_pkg::CFG_DW-1:0]  cfg_data_i
);

  import ctl_pkg::*;

  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WORD_W = EXP_W + ID_BITS;

  logic [15:0]        timeslot_q;
  logic [7:0]         periods_q;
  logic               idle;
  logic               mem_re, mem_we;
  logic [IDX_W-1:0]   mem_raddr, mem_waddr;
  logic [WORD_W-1:0]  mem_wdata, mem_rdata;
  logic               out_free;
  push_t              push;
  logic [ID_BITS-1:0] push_id;
  logic [CNT_W-1:0]   count;

  // Configuration registers, written between requests.
  assign cfg_ready_o = idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeslot_q <= TIMESLOT_RST;
      periods_q  <= PERIODS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_addr_i == CFG_TIMESLOT) begin
        timeslot_q <= cfg_data_i;
      end
      if (cfg_addr_i == CFG_PERIODS) begin
        periods_q <= cfg_data_i[7:0];
      end
    end
  end

  // A pending configuration write goes first, so a request never starts
  // in the same cycle as a register change.
  assign in_stall_o = !idle || cfg_valid_i;

  ctl_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i && !cfg_valid_i),
    .idle_o        (idle),
    .cmd_i         (cmd_e'(cmd_i)),
    .conn_id_i     (conn_id_i),
    .now_seconds_i (now_seconds_i),
    .timeslot_i    (timeslot_q),
    .periods_i     (periods_q),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata),
    .out_free_i    (out_free),
    .push_o        (push),
    .push_id_o     (push_id),
    .count_o       (count)
  );

  ctl_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (WORD_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ctl_out #(
    .ID_BITS (ID_BITS)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_id_i    (push_id),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .expired_id_o (expired_id_o),
    .last_o       (last_o)
  );

  // The entry count never exceeds the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // An accepted request always keeps the sequencer busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("sequencer idle right after accepting a request");

  // With no request accepted, an idle sequencer leaves the table alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && !in_valid_i) |=> $stable(count))
    else $error("entry count changed while idle");

  // A result is produced only while a request is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> in_stall_o)
    else $error("result pushed while idle");

endmodule

// ===== tb/connection_timeout_list_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_timeout_list_top_tb: self-checking bench of the timer list
// Drives add, refresh, remove and tick requests against a software copy of
// the ordered timer table and checks every result, field by field, in order.
// A short directed part covers the corner cases. Random phases follow under
// several register settings, including a phase that fills the table and a
// phase that holds off the receiver long enough to back up the input.
// ----------------------------------------------------------------------------
module connection_timeout_list_top_tb;
  import ctl_pkg::*;

  localparam int DEPTH        = 64;
  localparam int ID_W         = 10;
  localparam int WATCHDOG_MAX = 4000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [EXP_W-1:0] expiry;
    logic [ID_W-1:0]  id;
  } timer_t;

  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] id;
    logic            last;
  } outcome_t;

  // Software copy of the timer table and the queue of results it predicts.
  class timer_list_scoreboard;
    timer_t      timers[$];
    outcome_t    due_results[$];
    logic [15:0] slot_len;
    logic [7:0]  period_cnt;
    int          errors;
    int          requests;
    int          results;
    int          expired_cnt;
    int          full_cnt;
    int          missing_cnt;
    int          longest_burst;

    function new();
      slot_len      = TIMESLOT_RST;
      period_cnt    = PERIODS_RST;
      errors        = 0;
      requests      = 0;
      results       = 0;
      expired_cnt   = 0;
      full_cnt      = 0;
      missing_cnt   = 0;
      longest_burst = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      if (idx == CFG_TIMESLOT) begin
        slot_len = data;
      end else if (idx == CFG_PERIODS) begin
        period_cnt = data[7:0];
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // A stored id when there is one, so refresh and remove mostly hit.
    function logic [ID_W-1:0] stored_id();
      if (timers.size() == 0) return ID_W'($urandom_range(0, 15));
      return timers[$urandom_range(0, timers.size() - 1)].id;
    endfunction

    function int find_timer(logic [ID_W-1:0] id);
      for (int i = 0; i < timers.size(); i++) begin
        if (timers[i].id == id) return i;
      end
      return -1;
    endfunction

    // New entries go after every entry that expires at or before them.
    function void insert_timer(logic [ID_W-1:0] id, logic [EXP_W-1:0] due);
      int     pos;
      timer_t t;
      pos = 0;
      while (pos < timers.size() && timers[pos].expiry <= due) pos++;
      t.expiry = due;
      t.id     = id;
      timers.insert(pos, t);
    endfunction

    function void push_result(status_e status, logic [ID_W-1:0] id, logic last);
      outcome_t o;
      o.status = status;
      o.id     = id;
      o.last   = last;
      due_results.insert(due_results.size(), o);
    endfunction

    // Apply one accepted request and queue the results it must produce.
    function void note_request(cmd_e cmd, logic [ID_W-1:0] id, logic [NOW_W-1:0] now);
      logic [EXP_W-1:0] now_ext;
      logic [EXP_W-1:0] due;
      int               pos;
      int               burst;
      now_ext = EXP_W'(now);
      due     = now_ext + EXP_W'(period_cnt) * EXP_W'(slot_len);
      requests++;
      case (cmd)
        CMD_ADD: begin
          if (timers.size() >= DEPTH) begin
            push_result(STS_FULL, '0, 1'b1);
            full_cnt++;
          end else begin
            insert_timer(id, due);
            push_result(STS_DONE, '0, 1'b1);
          end
        end
        CMD_REFRESH, CMD_REMOVE: begin
          pos = find_timer(id);
          if (pos < 0) begin
            push_result(STS_NOT_FOUND, '0, 1'b1);
            missing_cnt++;
          end else begin
            timers.delete(pos);
            if (cmd == CMD_REFRESH) insert_timer(id, due);
            push_result(STS_DONE, '0, 1'b1);
          end
        end
        default: begin
          // Tick: expire from the front; last marks the final expired entry.
          burst = 0;
          while (timers.size() > 0 && timers[0].expiry <= now_ext) begin
            push_result(STS_EXPIRED, timers[0].id,
                        !(timers.size() > 1 && timers[1].expiry <= now_ext));
            void'(timers.pop_front());
            burst++;
          end
          if (burst == 0) push_result(STS_NONE, '0, 1'b1);
          expired_cnt += burst;
          if (burst > longest_burst) longest_burst = burst;
        end
      endcase
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic [2:0] status, logic [ID_W-1:0] id, logic last);
      outcome_t want;
      results++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request waiting: status %0d id %0d last %0d",
                 $time, status, id, last);
        return;
      end
      want = due_results.pop_front();
      if (status !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, status);
      end
      if (id !== want.id) begin
        errors++;
        $display("%0t: expired_id mismatch, expected %0d actual %0d",
                 $time, want.id, id);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last mismatch, expected %0d actual %0d",
                 $time, want.last, last);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni     = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall_o;
  logic [1:0]        cmd_r      = '0;
  logic [ID_W-1:0]   id_r       = '0;
  logic [NOW_W-1:0]  now_r      = '0;
  logic              out_valid_o;
  logic              out_stall  = 1'b0;
  logic [2:0]        status_o;
  logic [ID_W-1:0]   expired_id_o;
  logic              last_o;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [CFG_DW-1:0] cfg_data   = '0;

  timer_list_scoreboard sb;
  logic [NOW_W-1:0]     cur_now   = '0;
  bit                   no_gaps   = 1'b0;
  bit                   hold_request = 1'b0;
  int                   idle_cycles  = 0;

  connection_timeout_list_top #(
    .TABLE_DEPTH(DEPTH),
    .ID_BITS    (ID_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_r),
    .conn_id_i    (id_r),
    .now_seconds_i(now_r),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .status_o     (status_o),
    .expired_id_o (expired_id_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap lengths: mostly none or short, a few long.
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and return at the edge where it is taken.
  task automatic send_item(cmd_e cmd, logic [ID_W-1:0] id, logic [NOW_W-1:0] now);
    int unsigned gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd_r    <= cmd;
    id_r     <= id;
    now_r    <= now;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_request(cmd, id, now);
  endtask

  // Drop the request valid and wait until every predicted result is out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // One register write; the caller lowers cfg_valid after its last write.
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(logic [CFG_DW-1:0] slot, logic [CFG_DW-1:0] periods);
    write_reg(CFG_TIMESLOT, slot);
    write_reg(CFG_PERIODS, periods);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random request mix; ids mostly come from the table or a small pool.
  task automatic run_mix(int n, int unsigned step_max, int unsigned id_span);
    int unsigned      r;
    cmd_e             cmd;
    logic [ID_W-1:0]  id;
    logic [NOW_W-1:0] now_v;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) cmd = CMD_ADD;
      else if (r < 55) cmd = CMD_REFRESH;
      else if (r < 70) cmd = CMD_REMOVE;
      else cmd = CMD_TICK;
      r = $urandom_range(0, 99);
      if (r < 55) id = sb.stored_id();
      else if (r < 90) id = ID_W'($urandom_range(0, id_span));
      else id = ID_W'($urandom_range(0, 1023));
      cur_now = cur_now + $urandom_range(0, step_max);
      now_v   = ($urandom_range(0, 99) < 4) ? NOW_W'($urandom) : cur_now;
      send_item(cmd, id, now_v);
    end
  endtask

  // Result checking at the edge where a result is taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(status_o, expired_id_o, last_o);
    end
  end

  // Receiver stalls: short and long stretches, quiet stretches, one long hold.
  initial begin : rx_stall
    int unsigned r;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_stall <= 1'b0;
          repeat (150) @(posedge clk_i);
        end else begin
          out_stall <= (r < 55);
          r = $urandom_range(0, 99);
          if (r < 80) repeat ($urandom_range(1, 3)) @(posedge clk_i);
          else if (r < 95) repeat ($urandom_range(4, 10)) @(posedge clk_i);
          else repeat ($urandom_range(20, 60)) @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog on cycles in which no request, result or write is taken.
  always @(posedge clk_i) begin
    if ((in_valid && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready_o === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_MAX);
      $display("connection_timeout_list_top_tb NOT OK");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings (timeout of 15 seconds).
    send_item(CMD_TICK,    10'd0,    32'd0);
    send_item(CMD_REMOVE,  10'd5,    32'd0);
    send_item(CMD_REFRESH, 10'd5,    32'd0);
    send_item(CMD_ADD,     10'd0,    32'd0);
    send_item(CMD_ADD,     10'd1023, 32'd0);
    send_item(CMD_ADD,     10'd7,    32'd10);
    send_item(CMD_ADD,     10'd0,    32'd2);
    send_item(CMD_REFRESH, 10'd0,    32'd20);
    send_item(CMD_REMOVE,  10'd1023, 32'd0);
    send_item(CMD_TICK,    10'd0,    32'd16);
    send_item(CMD_TICK,    10'd0,    32'd25);
    send_item(CMD_ADD,     10'd3,    32'hFFFF_FFFF);
    send_item(CMD_TICK,    10'd0,    32'hFFFF_FFFF);
    send_item(CMD_REMOVE,  10'd3,    32'd0);

    // Zero registers make an entry expire at its own add time.
    wait_idle();
    program_regs(16'd0, 16'd0);
    send_item(CMD_ADD,  10'd9, 32'd100);
    send_item(CMD_TICK, 10'd0, 32'd99);
    send_item(CMD_TICK, 10'd0, 32'd100);

    // Unused register indexes, then the largest settings.
    wait_idle();
    write_reg(CFG_AW'(2), CFG_DW'($urandom));
    write_reg(CFG_AW'(3), CFG_DW'($urandom));
    program_regs(16'hFFFF, 16'hAB00 | 16'h00FF);
    send_item(CMD_ADD,     10'd1, 32'hFFFF_FFFF);
    send_item(CMD_ADD,     10'd2, 32'd0);
    send_item(CMD_TICK,    10'd0, 32'hFFFF_FFFF);
    send_item(CMD_REFRESH, 10'd1, 32'd5);
    send_item(CMD_REMOVE,  10'd1, 32'd0);

    // Random mix with short random timeouts.
    wait_idle();
    program_regs(CFG_DW'($urandom_range(1, 4)), CFG_DW'($urandom_range(1, 4)));
    cur_now = '0;
    run_mix(80, 3, 15);

    // Fill the table, overflow it, refresh while full, then expire it all.
    wait_idle();
    program_regs(16'd2, 16'd2);
    no_gaps = 1'b1;
    cur_now = 32'd1000;
    for (int i = 0; i < DEPTH + 2; i++) begin
      send_item(CMD_ADD, ID_W'($urandom_range(0, 1023)), cur_now + $urandom_range(0, 3));
    end
    send_item(CMD_REFRESH, sb.stored_id(), cur_now + 5);
    send_item(CMD_ADD,     ID_W'($urandom_range(0, 1023)), cur_now);
    send_item(CMD_REMOVE,  sb.stored_id(), cur_now);
    send_item(CMD_ADD,     ID_W'($urandom_range(0, 1023)), cur_now);
    no_gaps = 1'b0;
    send_item(CMD_TICK,    10'd0, cur_now + 100);
    send_item(CMD_TICK,    10'd0, cur_now + 100);

    // Largest timeout with time wrapping past the top of the counter.
    wait_idle();
    program_regs(16'hFFFF, 16'h00FF);
    cur_now = 32'hFFFF_FF00;
    run_mix(40, 32'h0040_0000, 15);

    // Timeout of one second; the receiver holds off for a long stretch here.
    wait_idle();
    program_regs(16'd1, 16'd1);
    hold_request = 1'b1;
    run_mix(110, 2, 15);

    // Drain and let the block settle.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests and %0d results: %0d expired (burst up to %0d),",
             sb.requests, sb.results, sb.expired_cnt, sb.longest_burst);
    $display("%0d rejected adds on a full table, %0d lookups of absent ids, %0d errors.",
             sb.full_cnt, sb.missing_cnt, sb.errors);
    if (sb.errors == 0) begin
      $display("connection_timeout_list_top_tb OK");
    end else begin
      $display("connection_timeout_list_top_tb NOT OK");
    end
    $finish;
  end

endmodule
